### rtl/framed_key_press_sequencer_core_assert.svh
// Assertion macros for the key press sequencer checker.
// No dependencies; included by files that hold assertions.
`ifndef FRAMED_KEY_PRESS_SEQUENCER_CORE_ASSERT_SVH
`define FRAMED_KEY_PRESS_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FKPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FKPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fkps_pkg.sv
// Shared types and constants of the framed key press sequencer.
// No dependencies.
package fkps_pkg;

  localparam int FRAME_BYTES   = 6;
  localparam int HEAD_DEPTH    = 5;
  localparam int RES_FIFO_DEPTH = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT   = 1'd1;

  localparam logic [7:0]  IDLE_TIMEOUT_RST = 8'd20;
  localparam logic [10:0] WRAP_LIMIT_RST   = 11'd2000;

  localparam logic [8:0]  SILENCE_MAX = 9'h1FF;
  localparam logic [16:0] HELD_MAX    = 17'h1FFFF;

  localparam logic [7:0] CMD_ENTER = 8'd1;
  localparam logic [7:0] CMD_UP    = 8'd2;
  localparam logic [7:0] CMD_DOWN  = 8'd3;

  localparam logic [7:0] DAC_ENTER = 8'd100;
  localparam logic [7:0] DAC_UP    = 8'd200;
  localparam logic [7:0] DAC_DOWN  = 8'd255;

  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    EV_PUSH    = 2'd0,
    EV_RELEASE = 2'd1,
    EV_FAIL    = 2'd2
  } event_e;

  typedef struct packed {
    event_e     ev;
    logic [7:0] key_code;
    logic       dac_write;
    logic       dac_channel;
    logic [7:0] dac_value;
    logic       last;
  } res_t;

  // up to two results per request, r0 first
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } res_push_t;

endpackage

### rtl/fkps_core.sv
// Frame collection, close/checksum and hold timing; builds results per request.
// Depends on fkps_pkg.
module fkps_core
  import fkps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_acc_i,
  input  logic                  in_kind_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  cfg_acc_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output res_push_t             push_o
);

  logic [7:0]  idle_q;
  logic [10:0] wrap_q;
  logic [10:0] count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  newest_q;
  logic [7:0]  head_q [HEAD_DEPTH];
  logic [8:0]  silence_q, silence_d;
  logic        held_q, held_d;
  logic [16:0] held_ticks_q, held_ticks_d;
  logic [15:0] hold_limit_q, hold_limit_d;

  logic [11:0] cnt_inc;
  logic [7:0]  sum_inc;
  logic [8:0]  sil_inc;
  logic [16:0] held_inc;
  logic [7:0]  check;
  logic        tick, is_byte, close, push, fail, release_ev;
  res_t        push_res, fail_res, rel_res;

  assign tick    = in_acc_i && in_kind_i;
  assign is_byte = in_acc_i && !in_kind_i;

  assign cnt_inc  = {1'b0, count_q} + 12'd1;
  assign sum_inc  = sum_q + in_byte_i;
  assign sil_inc  = (silence_q == SILENCE_MAX) ? silence_q : silence_q + 9'd1;
  assign held_inc = (held_ticks_q == HELD_MAX) ? held_ticks_q : held_ticks_q + 17'd1;
  assign check    = sum_q - newest_q;

  assign close      = (sil_inc > {1'b0, idle_q}) && (count_q != '0);
  assign push       = close && (check == newest_q) && (count_q == 11'(FRAME_BYTES));
  assign fail       = close && (check != newest_q);
  assign release_ev = held_q && !push && (held_inc > {1'b0, hold_limit_q});

  always_comb begin
    count_d      = count_q;
    sum_d        = sum_q;
    silence_d    = silence_q;
    held_d       = held_q;
    held_ticks_d = held_ticks_q;
    hold_limit_d = hold_limit_q;
    if (is_byte) begin
      silence_d = '0;
      if (cnt_inc >= {1'b0, wrap_q}) begin
        count_d = '0;
        sum_d   = '0;
      end else begin
        count_d = cnt_inc[10:0];
        sum_d   = sum_inc;
      end
    end else if (tick) begin
      silence_d = sil_inc;
      if (close) begin
        count_d = '0;
        sum_d   = '0;
      end
      if (push) begin
        held_d       = 1'b1;
        held_ticks_d = '0;
        hold_limit_d = {head_q[2], head_q[1]};
      end else if (held_q) begin
        held_ticks_d = held_inc;
        if (release_ev) begin
          held_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q       <= IDLE_TIMEOUT_RST;
      wrap_q       <= WRAP_LIMIT_RST;
      count_q      <= '0;
      sum_q        <= '0;
      newest_q     <= '0;
      silence_q    <= '0;
      held_q       <= 1'b0;
      held_ticks_q <= '0;
      hold_limit_q <= '0;
    end else begin
      if (cfg_acc_i) begin
        case (cfg_index_i)
          CFG_IDLE_TIMEOUT: idle_q <= cfg_data_i[7:0];
          CFG_WRAP_LIMIT:   wrap_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (is_byte) begin
        newest_q <= in_byte_i;
      end
      count_q      <= count_d;
      sum_q        <= sum_d;
      silence_q    <= silence_d;
      held_q       <= held_d;
      held_ticks_q <= held_ticks_d;
      hold_limit_q <= hold_limit_d;
    end
  end

  // head bytes: no reset, only read once a full frame has written them
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      if (is_byte && count_q == 11'(i)) begin
        head_q[i] <= in_byte_i;
      end
    end
  end

  always_comb begin
    push_res = '{ev: EV_PUSH, key_code: head_q[0], dac_write: 1'b0,
                 dac_channel: 1'b0, dac_value: 8'd0, last: 1'b1};
    case (head_q[0])
      CMD_ENTER: begin
        push_res.dac_write   = 1'b1;
        push_res.dac_channel = 1'b1;
        push_res.dac_value   = DAC_ENTER;
      end
      CMD_UP: begin
        push_res.dac_write   = 1'b1;
        push_res.dac_channel = 1'b0;
        push_res.dac_value   = DAC_UP;
      end
      CMD_DOWN: begin
        push_res.dac_write   = 1'b1;
        push_res.dac_channel = 1'b1;
        push_res.dac_value   = DAC_DOWN;
      end
      default: ;
    endcase
    fail_res = '{ev: EV_FAIL, key_code: 8'd0, dac_write: 1'b0,
                 dac_channel: 1'b0, dac_value: 8'd0, last: !release_ev};
    rel_res  = '{ev: EV_RELEASE, key_code: 8'd0, dac_write: 1'b0,
                 dac_channel: 1'b0, dac_value: 8'd0, last: 1'b1};
  end

  // push and release are exclusive; fail may be followed by release
  always_comb begin
    push_o.num = tick ? (2'(fail) + 2'(push) + 2'(release_ev)) : 2'd0;
    push_o.r0  = fail ? fail_res : (push ? push_res : rel_res);
    push_o.r1  = rel_res;
  end

endmodule

### rtl/fkps_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one.
// Depends on fkps_pkg.
module fkps_res_fifo
  import fkps_pkg::*;
#(
  parameter int DEPTH = RES_FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  input  logic      pop_i,
  output res_t      head_o,
  output logic      valid_o,
  output logic      room_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q, wr_next;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CNT_W'(DEPTH - 2));
  assign head_o  = mem_q[rd_q];
  assign wr_next = wr_q + PTR_W'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_i.num);
      rd_q  <= rd_q + PTR_W'(pop);
      cnt_q <= cnt_q + CNT_W'(push_i.num) - CNT_W'(pop);
    end
  end

endmodule

### rtl/framed_key_press_sequencer_core.sv
// Results of a tick request enter the result queue the cycle after it is taken.
// Throughput: one request per cycle while the result queue has room for two results;
// a tick giving failure and release gives two results, sent singly on the one-wide port.
// Byte requests give no results. Config writes are taken every cycle.
// Reset (rst_ni low, async) clears counters, sums, key state and the queue;
// idle_timeout_ms returns to 20 and wrap_limit to 2000.
module framed_key_press_sequencer_core
  import fkps_pkg::*;
#(
  parameter int RES_DEPTH = RES_FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  input  logic                  s_axis_tuser,   // [0] kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] key_code, [8] dac_write,
                                                // [9] dac_channel, [17:10] dac_value
  output logic [1:0]            m_axis_tuser,   // [1:0] event_res
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  res_push_t push;
  res_t      head;
  logic      room;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room;

  fkps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (s_axis_tvalid && s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .cfg_acc_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push)
  );

  fkps_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room_o  (room)
  );

  assign m_axis_tdata = {6'd0, head.dac_value, head.dac_channel, head.dac_write, head.key_code};
  assign m_axis_tuser = head.ev;
  assign m_axis_tlast = head.last;

endmodule

### rtl/fkps_checker.sv
// Port-level checks of the key press sequencer, bound to the top level.
// Depends on fkps_pkg and framed_key_press_sequencer_core_assert.svh.
`include "framed_key_press_sequencer_core_assert.svh"

module fkps_checker
  import fkps_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser,
  input logic                  m_axis_tlast
);

  logic                  tick_acc;
  logic                  out_idle;
  logic                  non_push;
  logic                  dac_wr;
  logic                  known_key;
  logic                  dac_ok;
  logic                  out_stall;
  logic [OUT_DATA_W+2:0] out_word;

  assign tick_acc  = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign out_idle  = !m_axis_tvalid;
  assign non_push  = m_axis_tvalid && (m_axis_tuser != EV_PUSH);
  assign dac_wr    = m_axis_tvalid && m_axis_tdata[8];
  assign known_key = m_axis_tdata[7:0] inside {CMD_ENTER, CMD_UP, CMD_DOWN};
  assign dac_ok    = (m_axis_tuser == EV_PUSH) && known_key;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // only a tick can create results
  `FKPS_ASSERT_NEXT(a_no_result_without_tick, out_idle && !tick_acc, out_idle, "result without tick")

  `FKPS_ASSERT_NOW(a_nonpush_zero_data, non_push, m_axis_tdata == '0, "release/failure carries data")

  `FKPS_ASSERT_NOW(a_dac_only_known_key, dac_wr, dac_ok, "DAC write on wrong result")

  `FKPS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled result changed")

endmodule

bind framed_key_press_sequencer_core fkps_checker u_fkps_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for framed_key_press_sequencer_core: serial bytes and ms ticks
// go in, push/release/failure events are predicted and checked in order.
// Depends on fkps_pkg and the core RTL.
module tb_top;
  import fkps_pkg::*;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam int IDLE_PCT     = 7;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } serial_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] rx_byte
  logic                  s_axis_tuser = 1'b0; // [0] kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [7:0] key_code, [8] dac_write,
                                              // [9] dac_channel, [17:10] dac_value
  logic [1:0]            m_axis_tuser;        // [1:0] event_res
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  framed_key_press_sequencer_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  serial_req_t pending_reqs[$];
  res_t        awaited_events[$];
  serial_req_t next_req;
  res_t        due_event;
  int          queued_items = 0;
  int          taken_items = 0;
  int          fail_count = 0;
  int          stall_cycles = 0;
  bit          req_taken = 1'b0;
  bit          calm = 1'b0;

  // predictor state
  logic [7:0]  timeout_cfg = IDLE_TIMEOUT_RST;
  logic [10:0] wrap_cfg = WRAP_LIMIT_RST;
  logic [10:0] frame_len = '0;
  logic [7:0]  frame_sum = '0;
  logic [7:0]  tail_byte = '0;
  logic [7:0]  head_q[HEAD_DEPTH] = '{default: '0};
  logic [8:0]  quiet_ticks = '0;
  bit          key_pressed = 1'b0;
  logic [16:0] press_ticks = '0;
  logic [15:0] press_limit = '0;

  task automatic predict_key_events(input logic kind, input logic [7:0] rx);
    logic [11:0] next_len;
    logic [7:0]  code;
    res_t        r;
    bit          pushed;
    int          first;
    pushed = 1'b0;
    first = awaited_events.size();
    if (kind == KIND_BYTE) begin
      if (frame_len < HEAD_DEPTH) head_q[3'(frame_len)] = rx;
      tail_byte = rx;
      frame_sum = frame_sum + rx;
      next_len = frame_len + 12'd1;
      if (next_len >= wrap_cfg) begin
        next_len = '0;
        frame_sum = '0;
      end
      frame_len = next_len[10:0];
      quiet_ticks = '0;
    end else begin
      if (quiet_ticks < SILENCE_MAX) quiet_ticks++;
      if (quiet_ticks > timeout_cfg && frame_len != 0) begin
        if (8'(frame_sum - tail_byte) == tail_byte) begin
          if (frame_len == FRAME_BYTES) begin
            code = head_q[0];
            r = '0;
            r.ev = EV_PUSH;
            r.key_code = code;
            case (code)
              CMD_ENTER: begin
                r.dac_write = 1'b1; r.dac_channel = 1'b1; r.dac_value = DAC_ENTER;
              end
              CMD_UP: begin
                r.dac_write = 1'b1; r.dac_channel = 1'b0; r.dac_value = DAC_UP;
              end
              CMD_DOWN: begin
                r.dac_write = 1'b1; r.dac_channel = 1'b1; r.dac_value = DAC_DOWN;
              end
              default: ;
            endcase
            press_limit = {head_q[2], head_q[1]};
            key_pressed = 1'b1;
            press_ticks = '0;
            pushed = 1'b1;
            awaited_events.push_back(r);
          end
        end else begin
          r = '0;
          r.ev = EV_FAIL;
          awaited_events.push_back(r);
        end
        frame_len = '0;
        frame_sum = '0;
      end
      // no release check on the push tick
      if (key_pressed && !pushed) begin
        if (press_ticks < HELD_MAX) press_ticks++;
        if (press_ticks > press_limit) begin
          key_pressed = 1'b0;
          r = '0;
          r.ev = EV_RELEASE;
          awaited_events.push_back(r);
        end
      end
      if (awaited_events.size() > first) begin
        r = awaited_events.pop_back();
        r.last = 1'b1;
        awaited_events.push_back(r);
      end
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // monitor, predictor feed and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_events.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0d",
                   $time, m_axis_tuser);
          fail_count++;
        end else begin
          due_event = awaited_events.pop_front();
          check_field("event_res", due_event.ev, m_axis_tuser);
          check_field("key_code", due_event.key_code, m_axis_tdata[7:0]);
          check_field("dac_write", due_event.dac_write, m_axis_tdata[8]);
          check_field("dac_channel", due_event.dac_channel, m_axis_tdata[9]);
          check_field("dac_value", due_event.dac_value, m_axis_tdata[17:10]);
          check_field("last", due_event.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_key_events(s_axis_tuser, s_axis_tdata);
        taken_items++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_IDLE_TIMEOUT) timeout_cfg = cfg_data_i[7:0];
        else if (cfg_index_i == CFG_WRAP_LIMIT) wrap_cfg = cfg_data_i[10:0];
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
    req_taken <= s_axis_tvalid && s_axis_tready;
  end

  // driver: requests from the pending queue, random stalls on both sides
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!s_axis_tvalid || req_taken) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= next_req.kind;
          s_axis_tdata <= next_req.rx_byte;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic add_req(input logic kind, input logic [7:0] rx_byte);
    serial_req_t r;
    r.kind = kind;
    r.rx_byte = rx_byte;
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  task automatic add_ticks(input int n);
    repeat (n) add_req(KIND_TICK, 8'($urandom_range(255)));
  endtask

  // len bytes, last one the checksum; short tick gaps inside never exceed the timeout
  task automatic add_frame(input int len, input logic [7:0] code, input logic [15:0] hold,
                           input bit bad_sum, input int gap);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    for (int i = 0; i < len - 1; i++) begin
      case (i)
        0: b = code;
        1: b = hold[7:0];
        2: b = hold[15:8];
        default: b = 8'($urandom_range(255));
      endcase
      add_req(KIND_BYTE, b);
      sum = sum + b;
      if (gap > 0 && $urandom_range(3) == 0) add_ticks($urandom_range(gap));
    end
    b = bad_sum ? sum + 8'd1 + 8'($urandom_range(254)) : sum;
    add_req(KIND_BYTE, b);
  endtask

  task automatic add_random_traffic(input int n_items, input int timeout);
    int          stop;
    int          pick;
    int          extra;
    logic [7:0]  code;
    logic [15:0] hold;
    stop = queued_items + n_items;
    while (queued_items < stop) begin
      pick = $urandom_range(99);
      hold = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
      case ($urandom_range(4))
        0: code = CMD_ENTER;
        1: code = CMD_UP;
        2: code = CMD_DOWN;
        default: code = 8'($urandom_range(255));
      endcase
      extra = (hold > 14) ? 16 : hold + 2;
      if (pick < 65) begin
        add_frame(FRAME_BYTES, code, hold, 1'b0, timeout);
        add_ticks(timeout + 1 + $urandom_range(extra));
      end else if (pick < 80) begin
        add_frame((pick < 72) ? FRAME_BYTES : $urandom_range(1, 9), code, hold,
                  pick < 72, timeout);
        add_ticks(timeout + 1 + $urandom_range(3));
      end else begin
        repeat ($urandom_range(1, 5)) add_req(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (taken_items != queued_items || awaited_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values
    add_frame(FRAME_BYTES, CMD_ENTER, 16'h0000, 1'b0, 0);
    add_ticks(22);
    wait_drained();

    cfg_write(CFG_IDLE_TIMEOUT, 11'd0);
    cfg_write(CFG_WRAP_LIMIT, 11'd2047);
    add_ticks(1);
    add_frame(FRAME_BYTES, CMD_UP, 16'h0001, 1'b0, 0);
    add_ticks(3);
    add_frame(FRAME_BYTES, 8'hFF, 16'hFFFF, 1'b0, 0);
    add_ticks(1);
    // push while held
    add_frame(FRAME_BYTES, CMD_DOWN, 16'h0000, 1'b0, 0);
    add_ticks(2);
    // push, then failure, then release on a short frame
    add_frame(FRAME_BYTES, 8'h00, 16'h0002, 1'b0, 0);
    add_ticks(2);
    add_frame(FRAME_BYTES, 8'h5A, 16'h0000, 1'b1, 0);
    add_ticks(1);
    add_frame(4, 8'h10, 16'h0000, 1'b0, 0);
    add_ticks(1);
    wait_drained();

    calm = 1'b1;
    add_random_traffic(60, 0);
    wait_drained();
    calm = 1'b0;

    cfg_write(CFG_IDLE_TIMEOUT, 11'd3);
    cfg_write(CFG_WRAP_LIMIT, 11'd7);
    add_random_traffic(70, 3);
    wait_drained();

    // long timeout, frame closes only once it has passed
    cfg_write(CFG_IDLE_TIMEOUT, 11'd100);
    cfg_write(CFG_WRAP_LIMIT, 11'd2047);
    add_frame(FRAME_BYTES, CMD_DOWN, 16'h0000, 1'b0, 0);
    add_ticks(102);
    add_req(KIND_BYTE, 8'h00);
    add_ticks(1);
    wait_drained();

    cfg_write(CFG_IDLE_TIMEOUT, 11'd1);
    cfg_write(CFG_WRAP_LIMIT, 11'd1);
    add_random_traffic(30, 1);
    wait_drained();

    cfg_write(CFG_IDLE_TIMEOUT, 11'($urandom_range(4)));
    cfg_write(CFG_WRAP_LIMIT, 11'($urandom_range(5, 40)));
    add_random_traffic(60, 4);
    wait_drained();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
